@@ hw/rtl/sbca_pkg.sv @@
// sbca_pkg: shared types, constants and helpers of the slab bitmap chunk allocator.
// No dependencies; every sbca_* module refers to it by scoped names.
package sbca_pkg;

  localparam int CHUNK_SLOTS = 4096;
  localparam int WORD_BITS   = 64;
  localparam int WORD_COUNT  = (CHUNK_SLOTS + WORD_BITS - 1) / WORD_BITS;
  localparam int WORD_AW     = $clog2(WORD_COUNT);
  localparam int BIT_AW      = $clog2(WORD_BITS);
  localparam int IDX_W       = WORD_AW + BIT_AW;
  localparam int OFF_W       = 21;
  localparam int CNT_W       = 13;
  localparam int CSL_W       = 5;
  localparam int CFG_AW      = 2;

  localparam logic [WORD_BITS-1:0] ALL_ONES = {WORD_BITS{1'b1}};
  localparam logic [WORD_BITS-1:0] TOP_BIT  = {1'b1, {(WORD_BITS-1){1'b0}}};
  localparam logic [WORD_AW-1:0]   LAST_WORD = WORD_AW'(WORD_COUNT - 1);

  // Configuration register indexes
  localparam logic [CFG_AW-1:0] CFG_CHUNK_SIZE_LOG2    = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_FIRST_CHUNK_OFFSET = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_CHUNK_LIMIT        = 2'd2;

  // Operation codes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_RANGE     = 2'd2,
    STAT_NOT_ALLOC = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ASCAN,
    S_AOFF,
    S_FSUB,
    S_FIDX,
    S_FCHK,
    S_RESULT
  } state_t;

  // Bitmap write request
  typedef struct packed {
    logic                 en;
    logic [WORD_AW-1:0]   addr;
    logic [WORD_BITS-1:0] data;
  } bm_wr_t;

  // Result of examining one bitmap word during a scan
  typedef struct packed {
    logic              past_cap;
    logic              any_free;
    logic [BIT_AW-1:0] first;
  } scan_res_t;

  // Position of the most significant set bit counted from bit 63 (bit 63 -> 0).
  // Binary search, one halving per step.
  function automatic logic [BIT_AW-1:0] first_set(input logic [WORD_BITS-1:0] v);
    logic [WORD_BITS-1:0] x;
    logic [BIT_AW-1:0]    n;
    begin
      x = v;
      n = '0;
      if (x[63:32] == '0) begin
        n[5] = 1'b1;
        x = x << 32;
      end
      if (x[63:48] == '0) begin
        n[4] = 1'b1;
        x = x << 16;
      end
      if (x[63:56] == '0) begin
        n[3] = 1'b1;
        x = x << 8;
      end
      if (x[63:60] == '0) begin
        n[2] = 1'b1;
        x = x << 4;
      end
      if (x[63:62] == '0) begin
        n[1] = 1'b1;
        x = x << 2;
      end
      if (x[63] == 1'b0) begin
        n[0] = 1'b1;
      end
      return n;
    end
  endfunction

endpackage

@@ hw/rtl/sbca_bitmap_store.sv @@
// sbca_bitmap_store: usage bitmap memory, one write and one registered read port,
// with a valid bit per word so that reset frees every chunk at once. Uses sbca_pkg.
module sbca_bitmap_store (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [sbca_pkg::WORD_AW-1:0]  rd_addr,
  input  sbca_pkg::bm_wr_t              wr,
  output logic [sbca_pkg::WORD_BITS-1:0] rd_word
);

  logic [sbca_pkg::WORD_BITS-1:0]  mem [sbca_pkg::WORD_COUNT];
  logic [sbca_pkg::WORD_COUNT-1:0] word_valid_r;
  logic [sbca_pkg::WORD_BITS-1:0]  rd_data_r;
  logic                            rd_valid_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_valid_r <= '0;
      rd_valid_r   <= 1'b0;
    end else begin
      if (wr.en) begin
        word_valid_r[wr.addr] <= 1'b1;
      end
      rd_valid_r <= word_valid_r[rd_addr];
    end
  end

  // never-written word reads as all free
  assign rd_word = rd_valid_r ? rd_data_r : '0;

endmodule

@@ hw/rtl/sbca_word_scan.sv @@
// sbca_word_scan: examines one bitmap word: capacity bound, free mask, lowest free chunk.
// Uses sbca_pkg.
module sbca_word_scan (
  input  logic [sbca_pkg::WORD_BITS-1:0] word,
  input  logic [sbca_pkg::WORD_AW-1:0]   word_idx,
  input  logic [sbca_pkg::CNT_W-1:0]     cap,
  output sbca_pkg::scan_res_t            res
);

  logic [sbca_pkg::CNT_W-1:0]     base;
  logic [sbca_pkg::CNT_W-1:0]     rem;
  logic [sbca_pkg::WORD_BITS-1:0] avail;

  assign base = sbca_pkg::CNT_W'({word_idx, {sbca_pkg::BIT_AW{1'b0}}});
  assign rem  = cap - base;

  always_comb begin
    avail = ~word;
    // last partial word: keep only chunks below capacity
    if (rem[sbca_pkg::CNT_W-1:sbca_pkg::BIT_AW] == '0) begin
      avail = avail & ~(sbca_pkg::ALL_ONES >> rem[sbca_pkg::BIT_AW-1:0]);
    end
  end

  assign res.past_cap = (base >= cap);
  assign res.any_free = (avail != '0);
  assign res.first    = sbca_pkg::first_set(avail);

endmodule

@@ hw/rtl/slab_bitmap_chunk_allocator.sv @@
// slab_bitmap_chunk_allocator: top level; request sequencer, config registers, result register.
// Uses sbca_pkg, sbca_bitmap_store and sbca_word_scan.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------------------------
//  in      | input     | in_valid / in_stall    | in_operation, in_free_offset
//  out     | output    | out_valid / out_stall  | out_chunk_offset, out_status,
//          |           |                        | out_in_use_count, out_slab_full, out_slab_empty
//  cfg     | input     | cfg_we                 | cfg_index, cfg_wdata
//
// Allocate: N words scanned (1..64), one word a cycle through the single bitmap read port
//   and the word scan unit, then the offset step and the result step.
// Free: subtract, decode index, read-modify-write, result; the read-modify-write step is
//   skipped when the offset is rejected at decode.
// Reset clears the word valid bits at once; no clearing pass follows.
// in_stall is high while a request is in flight; a finished result waits in the output
//   register, so the next request is taken while out_stall holds the previous one.
module slab_bitmap_chunk_allocator (
  input  logic                          clk,
  input  logic                          rst_n,
  // request channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_operation,
  input  logic [sbca_pkg::OFF_W-1:0]    in_free_offset,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [sbca_pkg::OFF_W-1:0]    out_chunk_offset,
  output logic [1:0]                    out_status,
  output logic [sbca_pkg::CNT_W-1:0]    out_in_use_count,
  output logic                          out_slab_full,
  output logic                          out_slab_empty,
  // configuration
  input  logic                          cfg_we,
  input  logic [sbca_pkg::CFG_AW-1:0]   cfg_index,
  input  logic [sbca_pkg::OFF_W-1:0]    cfg_wdata
);

  // config registers
  logic [sbca_pkg::CSL_W-1:0] chunk_size_log2_r;
  logic [sbca_pkg::OFF_W-1:0] first_chunk_offset_r;
  logic [sbca_pkg::CNT_W-1:0] chunk_limit_r;
  logic [sbca_pkg::CNT_W-1:0] cap;

  sbca_pkg::state_t state_r, state_nxt;

  // working registers
  logic [sbca_pkg::WORD_AW-1:0] word_r, word_nxt;
  logic [sbca_pkg::IDX_W-1:0]   idx_r, idx_nxt;
  logic [sbca_pkg::OFF_W-1:0]   off_r, off_nxt;      // free offset, then result offset
  logic [sbca_pkg::OFF_W-1:0]   delta_r, delta_nxt;
  logic                         below_r, below_nxt;
  sbca_pkg::status_t            status_r, status_nxt;
  logic [sbca_pkg::CNT_W-1:0]   used_r, used_nxt;

  // result register
  logic                         out_valid_r;
  logic [sbca_pkg::OFF_W-1:0]   out_off_r;
  sbca_pkg::status_t            out_status_r;
  logic [sbca_pkg::CNT_W-1:0]   out_count_r;
  logic                         out_full_r;
  logic                         out_empty_r;

  logic                         in_xfer;
  logic                         out_load;

  logic [sbca_pkg::WORD_AW-1:0]   rd_addr;
  logic [sbca_pkg::WORD_BITS-1:0] rd_word;
  sbca_pkg::bm_wr_t               bm_wr;
  sbca_pkg::scan_res_t            scan;

  // free path decode
  logic [sbca_pkg::OFF_W:0]     align_mask;
  logic [sbca_pkg::OFF_W-1:0]   free_idx;
  logic                         free_misaligned;
  logic                         free_out_of_cap;
  logic [sbca_pkg::WORD_BITS-1:0] free_bit;
  logic                         alloc_hit;

  assign cap = (chunk_limit_r < sbca_pkg::CNT_W'(sbca_pkg::CHUNK_SLOTS)) ?
               chunk_limit_r : sbca_pkg::CNT_W'(sbca_pkg::CHUNK_SLOTS);

  sbca_bitmap_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (rd_addr),
    .wr      (bm_wr),
    .rd_word (rd_word)
  );

  sbca_word_scan u_scan (
    .word     (rd_word),
    .word_idx (word_r),
    .cap      (cap),
    .res      (scan)
  );

  assign in_xfer   = in_valid && !in_stall;
  assign alloc_hit = (state_r == sbca_pkg::S_ASCAN) && !scan.past_cap && scan.any_free;

  // misalignment mask is (1 << log2) - 1; wide shifts saturate to all ones
  assign align_mask      = ((sbca_pkg::OFF_W+1)'(1) << chunk_size_log2_r) -
                           (sbca_pkg::OFF_W+1)'(1);
  assign free_misaligned = (delta_r & align_mask[sbca_pkg::OFF_W-1:0]) != '0;
  assign free_idx        = delta_r >> chunk_size_log2_r;
  assign free_out_of_cap = free_idx >= sbca_pkg::OFF_W'(cap);
  assign free_bit        = sbca_pkg::TOP_BIT >> idx_r[sbca_pkg::BIT_AW-1:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sbca_pkg::S_IDLE: begin
        if (in_xfer) begin
          state_nxt = (in_operation == sbca_pkg::OP_ALLOC) ? sbca_pkg::S_ASCAN
                                                           : sbca_pkg::S_FSUB;
        end
      end
      sbca_pkg::S_ASCAN: begin
        if (scan.past_cap || scan.any_free || word_r == sbca_pkg::LAST_WORD) begin
          state_nxt = sbca_pkg::S_AOFF;
        end
      end
      sbca_pkg::S_AOFF:   state_nxt = sbca_pkg::S_RESULT;
      sbca_pkg::S_FSUB:   state_nxt = sbca_pkg::S_FIDX;
      sbca_pkg::S_FIDX: begin
        if (below_r || free_misaligned || free_out_of_cap) begin
          state_nxt = sbca_pkg::S_RESULT;
        end else begin
          state_nxt = sbca_pkg::S_FCHK;
        end
      end
      sbca_pkg::S_FCHK:   state_nxt = sbca_pkg::S_RESULT;
      sbca_pkg::S_RESULT: begin
        if (out_load) begin
          state_nxt = sbca_pkg::S_IDLE;
        end
      end
      default:            state_nxt = sbca_pkg::S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall = 1'b1;
    out_load = 1'b0;
    rd_addr  = '0;
    bm_wr    = '0;
    unique case (state_r)
      sbca_pkg::S_IDLE: begin
        in_stall = 1'b0;
      end
      sbca_pkg::S_ASCAN: begin
        rd_addr = word_r + sbca_pkg::WORD_AW'(1);    // prefetch the next word
        if (alloc_hit) begin
          bm_wr.en   = 1'b1;
          bm_wr.addr = word_r;
          bm_wr.data = rd_word | (sbca_pkg::TOP_BIT >> scan.first);
        end
      end
      sbca_pkg::S_FIDX: begin
        rd_addr = free_idx[sbca_pkg::IDX_W-1:sbca_pkg::BIT_AW];
      end
      sbca_pkg::S_FCHK: begin
        if ((rd_word & free_bit) != '0) begin
          bm_wr.en   = 1'b1;
          bm_wr.addr = idx_r[sbca_pkg::IDX_W-1:sbca_pkg::BIT_AW];
          bm_wr.data = rd_word & ~free_bit;
        end
      end
      sbca_pkg::S_RESULT: begin
        out_load = !out_valid_r || !out_stall;
      end
      sbca_pkg::S_AOFF, sbca_pkg::S_FSUB: begin
      end
      default: begin
      end
    endcase
  end

  // datapath next values
  always_comb begin
    word_nxt   = word_r;
    idx_nxt    = idx_r;
    off_nxt    = off_r;
    delta_nxt  = delta_r;
    below_nxt  = below_r;
    status_nxt = status_r;
    used_nxt   = used_r;
    case (state_r)
      sbca_pkg::S_IDLE: begin
        word_nxt   = '0;
        off_nxt    = in_free_offset;
        status_nxt = sbca_pkg::STAT_OK;
      end
      sbca_pkg::S_ASCAN: begin
        word_nxt = word_r + sbca_pkg::WORD_AW'(1);
        if (alloc_hit) begin
          idx_nxt  = {word_r, scan.first};
          used_nxt = used_r + sbca_pkg::CNT_W'(1);
        end else if (scan.past_cap || word_r == sbca_pkg::LAST_WORD) begin
          status_nxt = sbca_pkg::STAT_FULL;
        end
      end
      sbca_pkg::S_AOFF: begin
        // offset wraps to 21 bits, as does the shifted index
        if (status_r == sbca_pkg::STAT_OK) begin
          off_nxt = (sbca_pkg::OFF_W'(idx_r) << chunk_size_log2_r) + first_chunk_offset_r;
        end else begin
          off_nxt = '0;
        end
      end
      sbca_pkg::S_FSUB: begin
        below_nxt = off_r < first_chunk_offset_r;
        delta_nxt = off_r - first_chunk_offset_r;
        off_nxt   = '0;
      end
      sbca_pkg::S_FIDX: begin
        idx_nxt = free_idx[sbca_pkg::IDX_W-1:0];
        if (below_r || free_misaligned || free_out_of_cap) begin
          status_nxt = sbca_pkg::STAT_RANGE;
        end
      end
      sbca_pkg::S_FCHK: begin
        if ((rd_word & free_bit) == '0) begin
          status_nxt = sbca_pkg::STAT_NOT_ALLOC;
        end else if (used_r != '0) begin
          used_nxt = used_r - sbca_pkg::CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r              <= sbca_pkg::S_IDLE;
      used_r               <= '0;
      out_valid_r          <= 1'b0;
      chunk_size_log2_r    <= sbca_pkg::CSL_W'(3);
      first_chunk_offset_r <= sbca_pkg::OFF_W'(64);
      chunk_limit_r        <= sbca_pkg::CNT_W'(4096);
    end else begin
      state_r <= state_nxt;
      used_r  <= used_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          sbca_pkg::CFG_CHUNK_SIZE_LOG2:
            chunk_size_log2_r <= cfg_wdata[sbca_pkg::CSL_W-1:0];
          sbca_pkg::CFG_FIRST_CHUNK_OFFSET:
            first_chunk_offset_r <= cfg_wdata;
          sbca_pkg::CFG_CHUNK_LIMIT:
            chunk_limit_r <= cfg_wdata[sbca_pkg::CNT_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    word_r   <= word_nxt;
    idx_r    <= idx_nxt;
    off_r    <= off_nxt;
    delta_r  <= delta_nxt;
    below_r  <= below_nxt;
    status_r <= status_nxt;
    if (out_load) begin
      out_off_r    <= off_r;
      out_status_r <= status_r;
      out_count_r  <= used_r;
      out_full_r   <= used_r >= cap;
      out_empty_r  <= used_r == '0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_chunk_offset = out_off_r;
  assign out_status       = out_status_r;
  assign out_in_use_count = out_count_r;
  assign out_slab_full    = out_full_r;
  assign out_slab_empty   = out_empty_r;

`ifndef SYNTHESIS
  // a new result only ever comes out of the result state
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == sbca_pkg::S_RESULT))
    else $error("result register loaded outside result state");

  // a successful allocation adds exactly one to the use count
  a_alloc_count: assert property (@(posedge clk) disable iff (!rst_n)
    alloc_hit |=> used_r == $past(used_r) + sbca_pkg::CNT_W'(1))
    else $error("use count not advanced on allocation");

  // the count never exceeds the bitmap size
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= sbca_pkg::CNT_W'(sbca_pkg::CHUNK_SLOTS))
    else $error("use count beyond bitmap size");

  // a result held under stall must not be overwritten
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !out_load)
    else $error("stalled result overwritten");
`endif

endmodule
